[rtl/psa_pkg.sv]
// Shared types, codes and default sizes for the page slot allocator.
// Used by the slot search, the top level and the testbench; depends on nothing else.
`default_nettype none

package psa_pkg;

    // Default sizes handed to the top-level parameters.
    localparam int DEF_MAX_PAGES  = 64;
    localparam int DEF_MAX_SLOTS  = 32;
    localparam int DEF_FIRST_PAGE = 1;

    // Register and port widths fixed by the interface.
    localparam int SPP_W       = 6;
    localparam int SLOT_IDX_W  = 6;
    localparam logic [SPP_W-1:0] SPP_RESET = 6'd32;

    // Request codes.
    typedef enum logic [1:0] {
        OP_ALLOC = 2'd0,
        OP_PLACE = 2'd1,
        OP_FREE  = 2'd2,
        OP_CHECK = 2'd3
    } psa_op_t;

    // Result status codes.
    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NOT_OCC   = 3'd1,
        ST_NO_PAGE   = 3'd2,
        ST_OUT_PAGES = 3'd3,
        ST_PAGE_FULL = 3'd4
    } psa_status_t;

    // Answer of the lowest-clear-slot search.
    typedef struct packed {
        logic                  found;
        logic [SLOT_IDX_W-1:0] slot;
    } psa_find_t;

endpackage

`default_nettype wire

[rtl/psa_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing; instantiated for the page entries and the list links.
`default_nettype none

module psa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

[rtl/psa_slot_find.sv]
// Finds the lowest clear slot of a page bitmap below the active slot limit.
// Depends on psa_pkg for the search answer type.
`default_nettype none

module psa_slot_find #(
    parameter int MAX_SLOTS = psa_pkg::DEF_MAX_SLOTS,
    localparam int CW       = $clog2(MAX_SLOTS + 1)
) (
    input  wire logic [MAX_SLOTS-1:0] occ,
    input  wire logic [CW-1:0]        limit,
    output psa_pkg::psa_find_t        find
);

    // Priority encoder: scan from the top so the lowest clear slot wins.
    always_comb
    begin
        find.found = 1'b0;
        find.slot  = '0;
        for (int i = MAX_SLOTS - 1; i >= 0; i--)
        begin
            if (!occ[i] && (i < int'(limit)))
            begin
                find.found = 1'b1;
                find.slot  = psa_pkg::SLOT_IDX_W'(i);
            end
        end
    end

endmodule

`default_nettype wire

[rtl/page_slot_allocator.sv]
// Top level of the page slot allocator: request sequencer, page entry RAM and link RAM.
// Depends on psa_pkg, psa_ram and psa_slot_find.
//
//  Channel   Signals                                        Handshake
//  --------  ---------------------------------------------  ------------------------------
//  request   operation, page_number, slot_number            beat taken when start & !busy
//  result    status, result_page, result_slot               beat valid while done is high
//  config    cfg_wr_data (slots per page)                   written when cfg_wr_en is high
//
// A request reads the page entry and its link from the RAMs at the accepting edge; the
// execute state then modifies and writes them back and registers the result. done rises
// in the cycle after that, and a new request can be taken in the same cycle unless a list
// walk follows: a place that fills a page walks the free-page list to unlink it, checking
// each entry passed and reading its link, then splicing the page out and giving it an end
// link (it stops at the check when the page is not on the list); busy stays high meanwhile.
// Reset is asynchronous and needs no clearing pass: a page entry is written when the page
// opens. The receiver cannot stall; each result is shown for exactly one cycle.
`default_nettype none

module page_slot_allocator #(
    parameter int MAX_PAGES  = psa_pkg::DEF_MAX_PAGES,
    parameter int MAX_SLOTS  = psa_pkg::DEF_MAX_SLOTS,
    parameter int FIRST_PAGE = psa_pkg::DEF_FIRST_PAGE
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    output logic                           busy,
    input  wire logic [1:0]                operation,
    input  wire logic [5:0]                page_number,
    input  wire logic [4:0]                slot_number,
    output logic                           done,
    output logic [2:0]                     status,
    output logic [5:0]                     result_page,
    output logic [4:0]                     result_slot,
    input  wire logic                      cfg_wr_en,
    input  wire logic [psa_pkg::SPP_W-1:0] cfg_wr_data
);

    localparam int AW  = $clog2(MAX_PAGES);
    localparam int LW  = $clog2(2 * MAX_PAGES);
    localparam int PCW = $clog2(MAX_PAGES + 1);
    localparam int CW  = $clog2(MAX_SLOTS + 1);
    localparam int EW  = MAX_SLOTS + CW;
    localparam logic [LW-1:0] NO_PAGE = LW'(2 * MAX_PAGES - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_WALK_CHK,
        S_WALK_RD,
        S_WALK_FIX
    } state_t;

    state_t                      state_reg, state_next;
    psa_pkg::psa_op_t            op_reg, op_next;
    logic [5:0]                  pg_reg, pg_next;
    logic [4:0]                  sl_reg, sl_next;
    logic [LW-1:0]               head_reg, head_next;
    logic [PCW-1:0]              page_count_reg, page_count_next;
    logic [psa_pkg::SPP_W-1:0]   spp_reg, spp_next;
    logic [LW-1:0]               cur_reg, cur_next;
    logic [LW-1:0]               prev_reg, prev_next;
    logic [PCW-1:0]              iter_reg, iter_next;
    logic                        done_reg, done_next;
    psa_pkg::psa_status_t        status_reg, status_next;
    logic [5:0]                  rpage_reg, rpage_next;
    logic [4:0]                  rslot_reg, rslot_next;

    // RAM ports.
    logic          entry_we, entry_re;
    logic [AW-1:0] entry_wa, entry_ra;
    logic [EW-1:0] entry_wd, entry_rd;
    logic          link_we, link_re;
    logic [AW-1:0] link_wa, link_ra;
    logic [LW-1:0] link_wd, link_rd;

    // Datapath terms.
    logic [MAX_SLOTS-1:0] rd_occ, alloc_occ, sl_mask, find_mask;
    logic [CW-1:0]        rd_used, alloc_used, n_eff;
    logic [CW:0]          rd_used_inc, alloc_used_inc;
    logic [LW-1:0]        alloc_p, alloc_lnk, pg_link;
    logic                 list_empty, alloc_exists, pg_exists, slot_ok, slot_bit;
    logic                 accept;
    psa_pkg::psa_find_t   find;

    // Page entries: occupancy bitmap and used count.
    psa_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_PAGES)
    ) u_entry_ram (
        .clk     (clk),
        .wr_en   (entry_we),
        .wr_addr (entry_wa),
        .wr_data (entry_wd),
        .rd_en   (entry_re),
        .rd_addr (entry_ra),
        .rd_data (entry_rd)
    );

    // Free-page list links.
    psa_ram #(
        .WIDTH (LW),
        .DEPTH (MAX_PAGES)
    ) u_link_ram (
        .clk     (clk),
        .wr_en   (link_we),
        .wr_addr (link_wa),
        .wr_data (link_wd),
        .rd_en   (link_re),
        .rd_addr (link_ra),
        .rd_data (link_rd)
    );

    // Lowest clear slot of the page taken by an alloc.
    psa_slot_find #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_slot_find (
        .occ   (alloc_occ),
        .limit (n_eff),
        .find  (find)
    );

    assign busy   = (state_reg != S_IDLE);
    assign accept = start && !busy;
    assign done        = done_reg;
    assign status      = status_reg;
    assign result_page = rpage_reg;
    assign result_slot = rslot_reg;

    // Shared terms of the execute cycle.
    always_comb
    begin
        n_eff = (int'(spp_reg) > MAX_SLOTS) ? CW'(MAX_SLOTS) : CW'(spp_reg);

        rd_occ      = entry_rd[MAX_SLOTS-1:0];
        rd_used     = entry_rd[EW-1:MAX_SLOTS];
        rd_used_inc = {1'b0, rd_used} + 1'b1;

        // An alloc on an empty list opens the next new page with a blank entry.
        list_empty     = (head_reg == NO_PAGE);
        alloc_p        = list_empty ? LW'(page_count_reg) : head_reg;
        alloc_occ      = list_empty ? '0 : rd_occ;
        alloc_used     = list_empty ? '0 : rd_used;
        alloc_lnk      = list_empty ? NO_PAGE : link_rd;
        alloc_used_inc = {1'b0, alloc_used} + 1'b1;
        alloc_exists   = list_empty ||
                         ((int'(alloc_p) >= FIRST_PAGE) &&
                          (int'(alloc_p) < int'(page_count_reg)) &&
                          (int'(alloc_p) < MAX_PAGES));
        find_mask      = MAX_SLOTS'(1) << find.slot;

        pg_exists = (int'(pg_reg) >= FIRST_PAGE) &&
                    (int'(pg_reg) < int'(page_count_reg)) &&
                    (int'(pg_reg) < MAX_PAGES);
        pg_link   = LW'(pg_reg);
        slot_ok   = (int'(sl_reg) < int'(n_eff));
        sl_mask   = MAX_SLOTS'(1) << sl_reg;
        slot_bit  = |(rd_occ & sl_mask);
    end

    // Sequencer: next state, RAM accesses and result.
    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        pg_next         = pg_reg;
        sl_next         = sl_reg;
        head_next       = head_reg;
        page_count_next = page_count_reg;
        spp_next        = cfg_wr_en ? cfg_wr_data : spp_reg;
        cur_next        = cur_reg;
        prev_next       = prev_reg;
        iter_next       = iter_reg;
        done_next       = 1'b0;
        status_next     = status_reg;
        rpage_next      = rpage_reg;
        rslot_next      = rslot_reg;

        entry_re = 1'b0;
        entry_ra = '0;
        entry_we = 1'b0;
        entry_wa = '0;
        entry_wd = '0;
        link_re  = 1'b0;
        link_ra  = '0;
        link_we  = 1'b0;
        link_wa  = '0;
        link_wd  = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                // Read the addressed page, or the list head for an alloc.
                if (accept)
                begin
                    op_next  = psa_pkg::psa_op_t'(operation);
                    pg_next  = page_number;
                    sl_next  = slot_number;
                    entry_re = 1'b1;
                    link_re  = 1'b1;
                    entry_ra = (psa_pkg::psa_op_t'(operation) == psa_pkg::OP_ALLOC)
                               ? head_reg[AW-1:0] : AW'(page_number);
                    link_ra  = entry_ra;
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                done_next  = 1'b1;
                state_next = S_IDLE;
                rpage_next = pg_reg;
                rslot_next = sl_reg;
                unique case (op_reg)
                    psa_pkg::OP_ALLOC:
                    begin
                        rpage_next = '0;
                        rslot_next = '0;
                        if (list_empty && (int'(page_count_reg) >= MAX_PAGES))
                        begin
                            status_next = psa_pkg::ST_OUT_PAGES;
                        end
                        else
                        begin
                            // Opening a page writes its blank entry and an end link.
                            if (list_empty)
                            begin
                                page_count_next = page_count_reg + 1'b1;
                                head_next       = alloc_p;
                                entry_we        = 1'b1;
                                entry_wa        = alloc_p[AW-1:0];
                                entry_wd        = '0;
                                link_we         = 1'b1;
                                link_wa         = alloc_p[AW-1:0];
                                link_wd         = NO_PAGE;
                            end
                            if (!alloc_exists)
                            begin
                                status_next = psa_pkg::ST_NO_PAGE;
                            end
                            else if (!find.found)
                            begin
                                status_next = psa_pkg::ST_PAGE_FULL;
                            end
                            else
                            begin
                                status_next = psa_pkg::ST_OK;
                                rpage_next  = 6'(alloc_p);
                                rslot_next  = 5'(find.slot);
                                entry_we    = 1'b1;
                                entry_wa    = alloc_p[AW-1:0];
                                entry_wd    = {CW'(alloc_used_inc), alloc_occ | find_mask};
                                // A page that fills leaves the head of the list.
                                if (alloc_used_inc >= (CW+1)'(n_eff))
                                begin
                                    head_next = alloc_lnk;
                                    link_we   = 1'b1;
                                    link_wa   = alloc_p[AW-1:0];
                                    link_wd   = NO_PAGE;
                                end
                            end
                        end
                    end

                    psa_pkg::OP_CHECK:
                    begin
                        status_next = (pg_exists && slot_ok && slot_bit)
                                      ? psa_pkg::ST_OK : psa_pkg::ST_NOT_OCC;
                    end

                    psa_pkg::OP_PLACE:
                    begin
                        if (!pg_exists)
                        begin
                            status_next = psa_pkg::ST_NO_PAGE;
                        end
                        else if (!slot_ok)
                        begin
                            status_next = psa_pkg::ST_NOT_OCC;
                        end
                        else
                        begin
                            status_next = psa_pkg::ST_OK;
                            if (!slot_bit)
                            begin
                                entry_we = 1'b1;
                                entry_wa = AW'(pg_reg);
                                entry_wd = {CW'(rd_used_inc), rd_occ | sl_mask};
                                // A page filled by place is unlinked wherever it stands.
                                if (rd_used_inc >= (CW+1)'(n_eff))
                                begin
                                    cur_next   = head_reg;
                                    prev_next  = NO_PAGE;
                                    iter_next  = '0;
                                    state_next = S_WALK_CHK;
                                end
                            end
                        end
                    end

                    psa_pkg::OP_FREE:
                    begin
                        if (!pg_exists)
                        begin
                            status_next = psa_pkg::ST_NO_PAGE;
                        end
                        else if (!slot_ok || !slot_bit)
                        begin
                            status_next = psa_pkg::ST_NOT_OCC;
                        end
                        else
                        begin
                            status_next = psa_pkg::ST_OK;
                            entry_we    = 1'b1;
                            entry_wa    = AW'(pg_reg);
                            entry_wd    = {(rd_used != '0) ? rd_used - 1'b1 : rd_used,
                                           rd_occ & ~sl_mask};
                            // A page that was full goes back to the head of the list.
                            if ({1'b0, rd_used} >= (CW+1)'(n_eff))
                            begin
                                head_next = pg_link;
                                link_we   = 1'b1;
                                link_wa   = AW'(pg_reg);
                                link_wd   = head_reg;
                            end
                        end
                    end
                endcase
            end

            S_WALK_CHK:
            begin
                // Stop at the end of the list or after the bounded number of steps.
                priority if (int'(cur_reg) >= MAX_PAGES)
                begin
                    state_next = S_IDLE;
                end
                else if ((cur_reg != pg_link) && (iter_reg == PCW'(MAX_PAGES)))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    link_re    = 1'b1;
                    link_ra    = cur_reg[AW-1:0];
                    state_next = S_WALK_RD;
                end
            end

            S_WALK_RD:
            begin
                if (cur_reg == pg_link)
                begin
                    // Splice the page out: its successor goes to its predecessor.
                    if (prev_reg == NO_PAGE)
                    begin
                        head_next = link_rd;
                    end
                    else
                    begin
                        link_we = 1'b1;
                        link_wa = prev_reg[AW-1:0];
                        link_wd = link_rd;
                    end
                    state_next = S_WALK_FIX;
                end
                else
                begin
                    prev_next  = cur_reg;
                    cur_next   = link_rd;
                    iter_next  = iter_reg + 1'b1;
                    state_next = S_WALK_CHK;
                end
            end

            S_WALK_FIX:
            begin
                // The unlinked page gets an end link.
                link_we    = 1'b1;
                link_wa    = AW'(pg_reg);
                link_wd    = NO_PAGE;
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            op_reg         <= psa_pkg::OP_ALLOC;
            pg_reg         <= '0;
            sl_reg         <= '0;
            head_reg       <= NO_PAGE;
            page_count_reg <= PCW'(FIRST_PAGE);
            spp_reg        <= psa_pkg::SPP_RESET;
            cur_reg        <= NO_PAGE;
            prev_reg       <= NO_PAGE;
            iter_reg       <= '0;
            done_reg       <= 1'b0;
            status_reg     <= psa_pkg::ST_OK;
            rpage_reg      <= '0;
            rslot_reg      <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            op_reg         <= op_next;
            pg_reg         <= pg_next;
            sl_reg         <= sl_next;
            head_reg       <= head_next;
            page_count_reg <= page_count_next;
            spp_reg        <= spp_next;
            cur_reg        <= cur_next;
            prev_reg       <= prev_next;
            iter_reg       <= iter_next;
            done_reg       <= done_next;
            status_reg     <= status_next;
            rpage_reg      <= rpage_next;
            rslot_reg      <= rslot_next;
        end
    end

endmodule

`default_nettype wire

[bench/page_slot_allocator_tb.sv]
// Self-checking testbench for the page slot allocator: directed and random requests,
// an in-bench prediction of the page bitmaps and free-page list, and a per-beat result check.
// Depends on psa_pkg and page_slot_allocator.

module page_slot_allocator_tb;

    localparam int MAX_PAGES     = psa_pkg::DEF_MAX_PAGES;
    localparam int MAX_SLOTS     = psa_pkg::DEF_MAX_SLOTS;
    localparam int FIRST_PAGE    = psa_pkg::DEF_FIRST_PAGE;
    localparam int SPP_W         = psa_pkg::SPP_W;
    localparam logic [6:0] NO_LINK = 7'(2 * MAX_PAGES - 1);
    localparam int CLK_PERIOD    = 10;
    localparam int CYCLE_LIMIT   = 1_000_000;
    // Longest list walk after a filling place, with some margin.
    localparam int SETTLE_CYCLES = 2 * MAX_PAGES + 8;

    typedef struct packed {
        psa_pkg::psa_status_t st;
        logic [5:0]           pg;
        logic [4:0]           sl;
    } slot_reply_t;

    typedef struct {
        slot_reply_t rep;
        int unsigned cyc;
    } pending_reply_t;

    logic       clk         = 1'b0;
    logic       rst_n       = 1'b0;
    logic       start       = 1'b0;
    logic [1:0] operation   = '0;
    logic [5:0] page_number = '0;
    logic [4:0] slot_number = '0;
    logic       cfg_wr_en   = 1'b0;
    logic [SPP_W-1:0] cfg_wr_data = '0;
    wire        busy;
    wire        done;
    wire  [2:0] status;
    wire  [5:0] result_page;
    wire  [4:0] result_slot;

    // Predicted allocator state.
    logic [MAX_SLOTS-1:0] occ_map   [MAX_PAGES];
    logic [5:0]           used_cnt  [MAX_PAGES];
    logic [6:0]           next_link [MAX_PAGES];
    logic [6:0]           list_head;
    logic [6:0]           pages_open;
    logic [SPP_W-1:0]     spp_reg;

    pending_reply_t replies_due [$];
    pending_reply_t head_due;
    slot_reply_t    last_reply;
    int unsigned    cycle_no = 0;
    int             idle_pct = 0;
    int             mismatches = 0;
    int             results_checked = 0;
    int             spp_writes = 0;
    int             op_count [4] = '{default: 0};
    int             status_seen [8] = '{default: 0};

    page_slot_allocator dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .operation   (operation),
        .page_number (page_number),
        .slot_number (slot_number),
        .done        (done),
        .status      (status),
        .result_page (result_page),
        .result_slot (result_slot),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    always @(posedge clk)
    begin
        cycle_no <= cycle_no + 1;
    end

    // ------------------------------------------------------------------
    // Allocator prediction
    // ------------------------------------------------------------------

    function automatic void reset_model();
        int i;
        for (i = 0; i < MAX_PAGES; i++)
        begin
            occ_map[i]   = '0;
            used_cnt[i]  = '0;
            next_link[i] = NO_LINK;
        end
        list_head  = NO_LINK;
        pages_open = 7'(FIRST_PAGE);
        spp_reg    = psa_pkg::SPP_RESET;
    endfunction

    // Register values above the page width saturate at the full page.
    function automatic int active_slots();
        return (spp_reg > MAX_SLOTS) ? MAX_SLOTS : int'(spp_reg);
    endfunction

    function automatic bit page_open(input logic [6:0] p);
        return p >= FIRST_PAGE && p < pages_open && p < MAX_PAGES;
    endfunction

    // Take a page out of the free-page list wherever it stands; the walk is bounded
    // so that a list that loops back on itself still ends.
    function automatic void drop_from_list(input logic [6:0] p);
        logic [6:0] prev;
        logic [6:0] cur;
        int i;
        prev = NO_LINK;
        cur  = list_head;
        for (i = 0; i < MAX_PAGES; i++)
        begin
            if (cur >= MAX_PAGES || cur == p)
                break;
            prev = cur;
            cur  = next_link[cur[5:0]];
        end
        if (cur != p)
            return;
        if (prev == NO_LINK)
            list_head = next_link[p[5:0]];
        else
            next_link[prev[5:0]] = next_link[p[5:0]];
        next_link[p[5:0]] = NO_LINK;
    endfunction

    // Apply one request to the predicted state and return the result it should give.
    function automatic slot_reply_t apply_request(input psa_pkg::psa_op_t op,
                                                  input logic [5:0] pg,
                                                  input logic [4:0] sl);
        slot_reply_t r;
        logic [6:0] p;
        int n;
        int s;
        bit full_before;
        n    = active_slots();
        r.st = psa_pkg::ST_OK;
        r.pg = pg;
        r.sl = sl;
        p    = {1'b0, pg};

        // Alloc: head of the free-page list, or a freshly opened page.
        if (op == psa_pkg::OP_ALLOC)
        begin
            r.pg = '0;
            r.sl = '0;
            if (list_head == NO_LINK && pages_open >= MAX_PAGES)
            begin
                r.st = psa_pkg::ST_OUT_PAGES;
                return r;
            end
            if (list_head == NO_LINK)
            begin
                occ_map[pages_open[5:0]]   = '0;
                used_cnt[pages_open[5:0]]  = '0;
                next_link[pages_open[5:0]] = NO_LINK;
                list_head = pages_open;
                pages_open++;
            end
            p = list_head;
            if (!page_open(p))
            begin
                r.st = psa_pkg::ST_NO_PAGE;
                return r;
            end
            s = 0;
            while (s < n && occ_map[p[5:0]][5'(s)])
                s++;
            if (s >= n)
            begin
                r.st = psa_pkg::ST_PAGE_FULL;
                return r;
            end
            occ_map[p[5:0]][5'(s)] = 1'b1;
            used_cnt[p[5:0]]++;
            if (used_cnt[p[5:0]] >= n)
            begin
                list_head         = next_link[p[5:0]];
                next_link[p[5:0]] = NO_LINK;
            end
            r.pg = p[5:0];
            r.sl = 5'(s);
            return r;
        end

        // Check folds every range problem into the not-occupied answer.
        if (op == psa_pkg::OP_CHECK)
        begin
            if (!page_open(p) || sl >= n || !occ_map[pg][sl])
                r.st = psa_pkg::ST_NOT_OCC;
            return r;
        end

        if (!page_open(p))
        begin
            r.st = psa_pkg::ST_NO_PAGE;
            return r;
        end
        if (sl >= n)
        begin
            r.st = psa_pkg::ST_NOT_OCC;
            return r;
        end

        // Place counts only a slot that was clear.
        if (op == psa_pkg::OP_PLACE)
        begin
            if (!occ_map[pg][sl])
            begin
                occ_map[pg][sl] = 1'b1;
                used_cnt[pg]++;
                if (used_cnt[pg] >= n)
                    drop_from_list(p);
            end
            return r;
        end

        // Free: a page that was full goes back to the head of the list.
        if (!occ_map[pg][sl])
        begin
            r.st = psa_pkg::ST_NOT_OCC;
            return r;
        end
        full_before = used_cnt[pg] >= n;
        occ_map[pg][sl] = 1'b0;
        if (used_cnt[pg] > 0)
            used_cnt[pg]--;
        if (full_before)
        begin
            next_link[pg] = list_head;
            list_head     = p;
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------

    function automatic void flag_field(input string name, input logic [5:0] want,
                                       input logic [5:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            mismatches++;
        end
    endfunction

    // Every result beat is taken at the edge that ends its cycle. A beat only matches
    // a prediction made at an earlier edge.
    always @(posedge clk)
    begin
        if (rst_n && done !== 1'b0)
        begin
            if (replies_due.size() == 0 || replies_due[0].cyc >= cycle_no)
            begin
                $display("%0t: result beat with nothing expected, expected none, %s",
                         $time, $sformatf("got %0d/%0d/%0d", status, result_page,
                                          result_slot));
                mismatches++;
            end
            else
            begin
                head_due = replies_due.pop_front();
                flag_field("status", 6'(head_due.rep.st), 6'(status));
                flag_field("result_page", head_due.rep.pg, result_page);
                flag_field("result_slot", 6'(head_due.rep.sl), 6'(result_slot));
                results_checked++;
                status_seen[head_due.rep.st]++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Hand one request beat to the block, then idle the request side at random.
    task automatic send_request(input psa_pkg::psa_op_t op, input logic [5:0] pg,
                                input logic [4:0] sl);
        pending_reply_t due;
        start       <= 1'b1;
        operation   <= op;
        page_number <= pg;
        slot_number <= sl;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        due.rep = apply_request(op, pg, sl);
        due.cyc = cycle_no;
        replies_due.push_back(due);
        last_reply = due.rep;
        op_count[op]++;
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
    endtask

    // Hold requests back until every predicted result has come and the block is idle.
    task automatic drain_replies();
        start <= 1'b0;
        do
            @(posedge clk);
        while (replies_due.size() != 0 || busy !== 1'b0);
    endtask

    task automatic write_slots_per_page(input logic [SPP_W-1:0] value);
        drain_replies();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        spp_reg = value;
        spp_writes++;
    endtask

    // Mostly requests on a small window of pages and in-range slots, so that pages
    // fill, leave the list and come back; the rest spans the open pages or the whole field range.
    task automatic random_request(input int hot_base);
        psa_pkg::psa_op_t op;
        logic [5:0] pg;
        logic [4:0] sl;
        int n;
        int pick;
        int k;
        n    = active_slots();
        pick = $urandom_range(99);
        if (pick < 30)
            op = psa_pkg::OP_ALLOC;
        else if (pick < 58)
            op = psa_pkg::OP_PLACE;
        else if (pick < 85)
            op = psa_pkg::OP_FREE;
        else
            op = psa_pkg::OP_CHECK;

        pick = $urandom_range(99);
        if (pick < 60)
            pg = 6'(hot_base + $urandom_range(3));
        else if (pick < 85 && pages_open > FIRST_PAGE + 1)
            pg = 6'($urandom_range(FIRST_PAGE, pages_open - 1));
        else
            pg = 6'($urandom_range(63));

        if (n > 0 && $urandom_range(99) < 80)
            sl = 5'($urandom_range(n - 1));
        else
            sl = 5'($urandom_range(31));

        // Steer most frees onto an occupied slot.
        if (op == psa_pkg::OP_FREE && page_open({1'b0, pg}) && occ_map[pg] != '0
            && $urandom_range(99) < 60)
        begin
            for (k = 0; k < 64 && !occ_map[pg][sl]; k++)
                sl = 5'($urandom_range(31));
        end
        send_request(op, pg, sl);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset size of 32 slots: page range, slot range, occupied and clear slots.
    task automatic test_directed_access();
        send_request(psa_pkg::OP_CHECK, 6'd0, 5'd0);
        send_request(psa_pkg::OP_PLACE, 6'd0, 5'd3);
        send_request(psa_pkg::OP_FREE, 6'd5, 5'd0);
        send_request(psa_pkg::OP_ALLOC, 6'd63, 5'd31);
        send_request(psa_pkg::OP_ALLOC, 6'd0, 5'd0);
        send_request(psa_pkg::OP_CHECK, 6'd1, 5'd1);
        send_request(psa_pkg::OP_CHECK, 6'd1, 5'd31);
        send_request(psa_pkg::OP_CHECK, 6'd63, 5'd31);
        send_request(psa_pkg::OP_PLACE, 6'd1, 5'd31);
        send_request(psa_pkg::OP_PLACE, 6'd1, 5'd31);
        send_request(psa_pkg::OP_FREE, 6'd1, 5'd30);
        send_request(psa_pkg::OP_FREE, 6'd1, 5'd0);
        send_request(psa_pkg::OP_ALLOC, 6'd0, 5'd0);
        send_request(psa_pkg::OP_PLACE, 6'd2, 5'd0);
    endtask

    // Four-slot pages: a page fills and leaves the list, a free brings it back, and a
    // place fills a page that sits behind the head of the list.
    task automatic test_small_pages();
        write_slots_per_page(6'd4);
        send_request(psa_pkg::OP_ALLOC, 6'd0, 5'd0);
        send_request(psa_pkg::OP_ALLOC, 6'd0, 5'd0);
        send_request(psa_pkg::OP_FREE, 6'd1, 5'd0);
        send_request(psa_pkg::OP_PLACE, 6'd2, 5'd1);
        send_request(psa_pkg::OP_PLACE, 6'd2, 5'd2);
        send_request(psa_pkg::OP_PLACE, 6'd2, 5'd3);
        send_request(psa_pkg::OP_PLACE, 6'd1, 5'd4);
        send_request(psa_pkg::OP_CHECK, 6'd2, 5'd3);
        send_request(psa_pkg::OP_ALLOC, 6'd0, 5'd0);
    endtask

    // Zero slots per page refuses everything; a value above the page width saturates.
    task automatic test_register_extremes();
        write_slots_per_page(6'd0);
        send_request(psa_pkg::OP_ALLOC, 6'd42, 5'd21);
        send_request(psa_pkg::OP_PLACE, 6'd3, 5'd0);
        send_request(psa_pkg::OP_CHECK, 6'd1, 5'd0);
        write_slots_per_page(6'd63);
        send_request(psa_pkg::OP_ALLOC, 6'd0, 5'd0);
        send_request(psa_pkg::OP_CHECK, 6'd3, 5'd31);
        send_request(psa_pkg::OP_PLACE, 6'd3, 5'd31);
    endtask

    // One-slot pages: every alloc fills a page, opening new ones once the list is empty, until none is left.
    task automatic test_page_exhaustion();
        logic [6:0] p;
        int i;
        // Clear slot 0 of the pages on the list first, so allocs cannot stall on them.
        p = list_head;
        for (i = 0; i < MAX_PAGES && p < MAX_PAGES; i++)
        begin
            if (occ_map[p[5:0]][0])
                send_request(psa_pkg::OP_FREE, p[5:0], 5'd0);
            p = next_link[p[5:0]];
        end
        write_slots_per_page(6'd1);
        for (i = 0; i < 2 * MAX_PAGES; i++)
        begin
            send_request(psa_pkg::OP_ALLOC, 6'($urandom_range(63)), 5'($urandom_range(31)));
            if (last_reply.st == psa_pkg::ST_OUT_PAGES)
                break;
        end
    endtask

    // One random phase at a given page size and idle rate, drained once midway.
    task automatic test_random_mix(input logic [SPP_W-1:0] spp, input int idle,
                                   input int count);
        int hot_base;
        int i;
        write_slots_per_page(spp);
        idle_pct = idle;
        hot_base = $urandom_range(FIRST_PAGE, MAX_PAGES - 4);
        for (i = 0; i < count; i++)
        begin
            if (i == count / 2)
                drain_replies();
            random_request(hot_base);
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial
    begin
        reset_model();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_access();
        test_small_pages();
        test_register_extremes();
        test_page_exhaustion();

        test_random_mix(6'd8, 0, 80);
        test_random_mix(6'd3, 62, 80);
        test_random_mix(6'd32, 35, 80);
        test_random_mix(6'd1, 0, 70);
        test_random_mix(6'd63, 62, 70);
        test_random_mix(6'd0, 35, 30);
        test_random_mix(6'd2, 0, 80);
        test_random_mix(6'd5, 62, 80);
        test_random_mix(6'd16, 35, 70);

        // Let any late or stray result beat show up before the verdict.
        drain_replies();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Run covered %0d requests (%0d alloc, %0d place, %0d free, %0d check),",
                 op_count[psa_pkg::OP_ALLOC] + op_count[psa_pkg::OP_PLACE] +
                 op_count[psa_pkg::OP_FREE] + op_count[psa_pkg::OP_CHECK],
                 op_count[psa_pkg::OP_ALLOC], op_count[psa_pkg::OP_PLACE],
                 op_count[psa_pkg::OP_FREE], op_count[psa_pkg::OP_CHECK]);
        $display("%0d page size writes, %0d results: %0d ok, %0d refused slot, %s",
                 spp_writes, results_checked, status_seen[psa_pkg::ST_OK],
                 status_seen[psa_pkg::ST_NOT_OCC],
                 $sformatf("%0d missing page, %0d out of pages, %0d no free slot.",
                           status_seen[psa_pkg::ST_NO_PAGE],
                           status_seen[psa_pkg::ST_OUT_PAGES],
                           status_seen[psa_pkg::ST_PAGE_FULL]));
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Watchdog for a block that stops answering.
    initial
    begin
        #(CYCLE_LIMIT * CLK_PERIOD);
        $display("Timed out after %0d cycles with %0d results outstanding",
                 CYCLE_LIMIT, replies_due.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
